### hdl/vaa_pkg.sv
// vaa_pkg: shared types and constants for the voxel attribute accumulator
// no dependencies; imported by vaa_front, vaa_back and the core top level
package vaa_pkg;

  localparam int ENTRIES   = 4;
  localparam int IDX_W     = $clog2(ENTRIES);
  localparam int AREA_W    = 32;
  localparam int RGBA_W    = 32;
  localparam int NORMAL_W  = 8;
  localparam int MAT_W     = 16;
  localparam int CH_W      = 8;
  localparam int CHANNELS  = RGBA_W / CH_W;
  localparam int CHAN_IDX_W = $clog2(CHANNELS);
  localparam int TOT_W     = AREA_W + IDX_W;
  localparam int ACC_W     = TOT_W + CH_W;
  localparam int PROD_W    = AREA_W + CH_W;
  localparam int DIV_STEPS = CH_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);
  localparam int QDEPTH    = 2;
  localparam int QPTR_W    = $clog2(QDEPTH);
  localparam int QCNT_W    = $clog2(QDEPTH + 1);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_AVERAGE_MODE   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_FALLBACK_ALPHA = CFG_IDX_W'(1);

  typedef struct packed {
    logic [AREA_W-1:0]   area;
    logic [RGBA_W-1:0]   rgba;
    logic [NORMAL_W-1:0] normal;
    logic [MAT_W-1:0]    material;
    logic                last;
    logic                area_nz;
  } vaa_item_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SCAN,
    BK_DIV_LOAD,
    BK_DIV,
    BK_DONE
  } back_state_t;

endpackage

### hdl/vaa_front.sv
// vaa_front: intake side, classifies items and holds them in a short queue
// depends on vaa_pkg
module vaa_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [vaa_pkg::AREA_W-1:0]    in_contribution_area,
  input  logic [vaa_pkg::RGBA_W-1:0]    in_sample_rgba,
  input  logic [vaa_pkg::NORMAL_W-1:0]  in_surface_normal,
  input  logic [vaa_pkg::MAT_W-1:0]     in_material_index,
  input  logic                          in_last_of_voxel,
  output logic                          q_valid,
  output vaa_pkg::vaa_item_t            q_item,
  input  logic                          q_pop
);
  import vaa_pkg::*;

  vaa_item_t          mem_r [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r;
  logic [QPTR_W-1:0]  rd_ptr_r;
  logic [QCNT_W-1:0]  cnt_r;
  logic               push;
  vaa_item_t          item_in;

  assign busy    = (cnt_r == QCNT_W'(QDEPTH));
  assign push    = start && !busy;
  assign q_valid = (cnt_r != '0);
  assign q_item  = mem_r[rd_ptr_r];

  // zero area is flagged here as area_nz, which the back end uses to decide whether an item is taken
  always_comb begin
    item_in.area     = in_contribution_area;
    item_in.rgba     = in_sample_rgba;
    item_in.normal   = in_surface_normal;
    item_in.material = in_material_index;
    item_in.last     = in_last_of_voxel;
    item_in.area_nz  = (in_contribution_area != '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (q_pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !q_pop) cnt_r <= cnt_r + 1'b1;
      else if (!push && q_pop) cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= item_in;
  end

`ifndef SYNTH
  a_pop_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("queue popped while empty");
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !q_pop) |=> (cnt_r == $past(cnt_r) + 1'b1) && (cnt_r <= QCNT_W'(QDEPTH)))
    else $error("queue fill count wrong after push");
`endif

endmodule

### hdl/vaa_back.sv
// vaa_back: execution side, merges items into the entry table and resolves voxels
// depends on vaa_pkg; fed from the vaa_front queue
module vaa_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_valid,
  input  vaa_pkg::vaa_item_t            q_item,
  output logic                          q_pop,
  input  logic                          average_mode,
  input  logic [vaa_pkg::CH_W-1:0]      fallback_alpha,
  output logic                          out_strobe,
  output logic                          out_accepted,
  output logic                          out_resolved,
  output logic [vaa_pkg::NORMAL_W-1:0]  out_dominant_normal,
  output logic [vaa_pkg::MAT_W-1:0]     out_dominant_material,
  output logic [vaa_pkg::RGBA_W-1:0]    out_resolved_rgba
);
  import vaa_pkg::*;

  back_state_t           state_r, state_nxt;

  logic [AREA_W-1:0]     area_r   [ENTRIES];
  logic [RGBA_W-1:0]     color_r  [ENTRIES];
  logic [NORMAL_W-1:0]   normal_r [ENTRIES];
  logic [MAT_W-1:0]      mat_r    [ENTRIES];

  logic [IDX_W-1:0]      idx_r;
  logic [CHAN_IDX_W-1:0] ch_r;
  logic [STEP_W-1:0]     step_r;
  logic [AREA_W-1:0]     best_area_r;
  logic [NORMAL_W-1:0]   best_nrm_r;
  logic [MAT_W-1:0]      best_mat_r;
  logic [RGBA_W-1:0]     best_col_r;
  logic [TOT_W-1:0]      total_r;
  logic [ACC_W-1:0]      acc_r [CHANNELS];
  logic [ACC_W-1:0]      rem_r;
  logic [ACC_W-1:0]      dvs_r;
  logic [CH_W-1:0]       quo_r;
  logic [RGBA_W-1:0]     mean_r;
  logic                  hold_acc_r;

  logic                  take_en, scan_en, div_load, div_en, res_en;
  logic                  hit, free_any, take_ok, single, table_empty;
  logic [IDX_W-1:0]      hit_idx, free_idx;
  logic [AREA_W-1:0]     sat_sum [ENTRIES];
  logic [AREA_W:0]       raw_sum [ENTRIES];
  logic [AREA_W-1:0]     scan_area;
  logic [RGBA_W-1:0]     scan_col;
  logic                  div_ge;
  logic [CH_W-1:0]       quo_fin;

  // match and free search, lowest entry wins
  always_comb begin
    hit      = 1'b0;
    hit_idx  = '0;
    free_any = 1'b0;
    free_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (area_r[i] != '0 && color_r[i] == q_item.rgba && normal_r[i] == q_item.normal) begin
        hit     = 1'b1;
        hit_idx = IDX_W'(i);
      end
      if (area_r[i] == '0) begin
        free_any = 1'b1;
        free_idx = IDX_W'(i);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      raw_sum[i] = {1'b0, area_r[i]} + {1'b0, q_item.area};
      sat_sum[i] = raw_sum[i][AREA_W] ? '1 : raw_sum[i][AREA_W-1:0];
    end
  end

  assign take_ok   = q_item.area_nz && (hit || free_any);
  assign single    = (area_r[1] == '0);
  assign scan_area = area_r[idx_r];
  assign scan_col  = color_r[idx_r];
  assign div_ge    = (rem_r >= dvs_r);
  assign quo_fin   = {quo_r[CH_W-2:0], div_ge};

  always_comb begin
    table_empty = 1'b1;
    for (int i = 0; i < ENTRIES; i++) begin
      if (area_r[i] != '0) table_empty = 1'b0;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (q_valid && q_item.last) state_nxt = BK_SCAN;
      end
      BK_SCAN: begin
        if (idx_r == IDX_W'(ENTRIES - 1)) begin
          state_nxt = (average_mode && !single) ? BK_DIV_LOAD : BK_DONE;
        end
      end
      BK_DIV_LOAD: state_nxt = BK_DIV;
      BK_DIV: begin
        if (step_r == STEP_W'(DIV_STEPS - 1)) begin
          state_nxt = (ch_r == CHAN_IDX_W'(CHANNELS - 1)) ? BK_DONE : BK_DIV_LOAD;
        end
      end
      BK_DONE: state_nxt = BK_IDLE;
      default: state_nxt = BK_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    q_pop    = 1'b0;
    scan_en  = 1'b0;
    div_load = 1'b0;
    div_en   = 1'b0;
    res_en   = 1'b0;
    case (state_r)
      BK_IDLE:     q_pop    = q_valid;
      BK_SCAN:     scan_en  = 1'b1;
      BK_DIV_LOAD: div_load = 1'b1;
      BK_DIV:      div_en   = 1'b1;
      BK_DONE:     res_en   = 1'b1;
      default:     q_pop    = 1'b0;
    endcase
  end

  assign take_en = q_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= BK_IDLE;
      out_strobe <= 1'b0;
      for (int i = 0; i < ENTRIES; i++) area_r[i] <= '0;
    end else begin
      state_r    <= state_nxt;
      out_strobe <= (take_en && !q_item.last) || res_en;
      if (res_en) begin
        for (int i = 0; i < ENTRIES; i++) area_r[i] <= '0;
      end else if (take_en && q_item.area_nz) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (hit && hit_idx == IDX_W'(i)) area_r[i] <= sat_sum[i];
          else if (!hit && free_any && free_idx == IDX_W'(i)) area_r[i] <= q_item.area;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take_en && q_item.area_nz && !hit && free_any) begin
      color_r[free_idx]  <= q_item.rgba;
      normal_r[free_idx] <= q_item.normal;
      mat_r[free_idx]    <= q_item.material;
    end

    if (take_en) begin
      hold_acc_r  <= take_ok;
      idx_r       <= '0;
      ch_r        <= '0;
      best_area_r <= '0;
      best_nrm_r  <= '0;
      best_mat_r  <= '0;
      best_col_r  <= {fallback_alpha, {(RGBA_W - CH_W){1'b0}}};
      total_r     <= '0;
      for (int c = 0; c < CHANNELS; c++) acc_r[c] <= '0;
    end

    if (scan_en) begin
      idx_r   <= idx_r + 1'b1;
      total_r <= total_r + TOT_W'(scan_area);
      for (int c = 0; c < CHANNELS; c++) begin
        acc_r[c] <= acc_r[c] + ACC_W'(PROD_W'(scan_area) * PROD_W'(scan_col[c*CH_W +: CH_W]));
      end
      if (scan_area > best_area_r) begin
        best_area_r <= scan_area;
        best_nrm_r  <= normal_r[idx_r];
        best_mat_r  <= mat_r[idx_r];
        best_col_r  <= scan_col;
      end
    end

    if (div_load) begin
      rem_r  <= acc_r[ch_r] + ACC_W'(total_r >> 1);
      dvs_r  <= ACC_W'(total_r) << (DIV_STEPS - 1);
      quo_r  <= '0;
      step_r <= '0;
    end

    if (div_en) begin
      if (div_ge) rem_r <= rem_r - dvs_r;
      dvs_r  <= dvs_r >> 1;
      quo_r  <= quo_fin;
      step_r <= step_r + 1'b1;
      if (step_r == STEP_W'(DIV_STEPS - 1)) begin
        mean_r[ch_r*CH_W +: CH_W] <= quo_fin;
        ch_r <= ch_r + 1'b1;
      end
    end

    if (take_en && !q_item.last) begin
      out_accepted          <= take_ok;
      out_resolved          <= 1'b0;
      out_dominant_normal   <= '0;
      out_dominant_material <= '0;
      out_resolved_rgba     <= '0;
    end else if (res_en) begin
      out_accepted <= hold_acc_r;
      out_resolved <= 1'b1;
      if (single) begin
        out_dominant_normal   <= (area_r[0] != '0) ? normal_r[0] : '0;
        out_dominant_material <= (area_r[0] != '0) ? mat_r[0] : '0;
        out_resolved_rgba     <= (area_r[0] != '0) ? color_r[0] : '0;
      end else begin
        out_dominant_normal   <= best_nrm_r;
        out_dominant_material <= best_mat_r;
        out_resolved_rgba     <= average_mode ? mean_r : best_col_r;
      end
    end
  end

`ifndef SYNTH
  a_done_emits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_DONE) |=> (out_strobe && out_resolved))
    else $error("resolve did not emit a resolved item");
  a_done_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_DONE) |=> table_empty)
    else $error("table not cleared after resolve");
  a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != BK_IDLE) |-> !q_pop)
    else $error("item popped while resolving");
`endif

endmodule

### hdl/voxel_attribute_accumulator_core.sv
// voxel_attribute_accumulator_core: top level, config registers, front and back
// depends on vaa_pkg, vaa_front, vaa_back
//
//   channel   signals                               handshake
//   -------   -----------------------------------   ----------------------------
//   input     in_* fields                           start high, busy low
//   result    out_* fields                          out_strobe, one cycle, no stall
//   config    cfg_we, cfg_index, cfg_wdata          cfg_we high, no wait
//
// an item not marked last reaches the outputs in the cycle after it is popped
// from the queue, so such items flow at one item per cycle while the back end
// is idle; a last item starts a serial scan of the table, and in average mode,
// when more than one entry is in use, the shared restoring divider then runs
// one channel at a time; busy rises only when the two-slot queue is full
// reset (rst_n low, synchronous) empties the queue and marks every entry free
module voxel_attribute_accumulator_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [vaa_pkg::AREA_W-1:0]      in_contribution_area,
  input  logic [vaa_pkg::RGBA_W-1:0]      in_sample_rgba,
  input  logic [vaa_pkg::NORMAL_W-1:0]    in_surface_normal,
  input  logic [vaa_pkg::MAT_W-1:0]       in_material_index,
  input  logic                            in_last_of_voxel,
  output logic                            out_strobe,
  output logic                            out_accepted,
  output logic                            out_resolved,
  output logic [vaa_pkg::NORMAL_W-1:0]    out_dominant_normal,
  output logic [vaa_pkg::MAT_W-1:0]       out_dominant_material,
  output logic [vaa_pkg::RGBA_W-1:0]      out_resolved_rgba,
  input  logic                            cfg_we,
  input  logic [vaa_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [vaa_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import vaa_pkg::*;

  // configuration, only to be written by the user while the block is idle (not enforced here)
  logic               avg_mode_r;
  logic [CH_W-1:0]    fb_alpha_r;

  // queue between the two halves
  logic               q_valid;
  vaa_item_t          q_item;
  logic               q_pop;

  // unknown register indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      avg_mode_r <= 1'b0;
      fb_alpha_r <= '0;
    end else if (cfg_we) begin
      if (cfg_index == CFG_AVERAGE_MODE) avg_mode_r <= cfg_wdata[0];
      else if (cfg_index == CFG_FALLBACK_ALPHA) fb_alpha_r <= cfg_wdata[CH_W-1:0];
    end
  end

  // intake: flags zero area and buffers items
  vaa_front u_front (
    .clk                  (clk),
    .rst_n                (rst_n),
    .start                (start),
    .busy                 (busy),
    .in_contribution_area (in_contribution_area),
    .in_sample_rgba       (in_sample_rgba),
    .in_surface_normal    (in_surface_normal),
    .in_material_index    (in_material_index),
    .in_last_of_voxel     (in_last_of_voxel),
    .q_valid              (q_valid),
    .q_item               (q_item),
    .q_pop                (q_pop)
  );

  // execution: table merge, scan, mean colour divide, result register
  vaa_back u_back (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .q_valid               (q_valid),
    .q_item                (q_item),
    .q_pop                 (q_pop),
    .average_mode          (avg_mode_r),
    .fallback_alpha        (fb_alpha_r),
    .out_strobe            (out_strobe),
    .out_accepted          (out_accepted),
    .out_resolved          (out_resolved),
    .out_dominant_normal   (out_dominant_normal),
    .out_dominant_material (out_dominant_material),
    .out_resolved_rgba     (out_resolved_rgba)
  );

endmodule
